// ===== rtl/core/hkc_pkg.sv =====
// Shared types and constants for the hashed key cache.
package hkc_pkg;

    // Field widths of the request and result items.
    localparam int KEY_W  = 64;
    localparam int TYPE_W = 8;
    localparam int COL_W  = 16;
    localparam int OCC_W  = 7;
    localparam int CAP_W  = 7;

    // Request modes.
    localparam logic MODE_CHECK  = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    // Configuration port layout.
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENABLE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAPACITY = 1'b1;
    localparam logic [CAP_W-1:0]     CAPACITY_RESET   = 7'd64;

    // FNV-1a 64-bit offset basis; the prime is 2^40 + 0x1B3.
    localparam logic [KEY_W-1:0] HASH_BASIS       = 64'hCBF29CE484222325;
    localparam int               HASH_PRIME_SHIFT = 40;
    localparam logic [8:0]       HASH_PRIME_LOW   = 9'h1B3;

    typedef logic [KEY_W-1:0] key_t;

endpackage

// ===== rtl/core/hashed_key_cache_fifo_evict_top.sv =====
// Hashed key cache with first-in first-out replacement: sequencer, stores and config.
// Each item is hashed and then, with the cache enabled, searched for by a linear key search
// over every slot, one entry per cycle; an insert that evicts then reads the oldest slot.
// With the cache disabled the search is skipped.
// One item at a time: busy stays high until the cycle that done pulses. Results cannot
// be stalled. After reset a clearing pass over every slot holds busy high.
module hashed_key_cache_fifo_evict_top #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             mode,
    input  hkc_pkg::key_t                    entity_key,
    input  logic [hkc_pkg::TYPE_W-1:0]       type_code,
    input  logic [hkc_pkg::COL_W-1:0]        column_number,
    output logic                             done,
    output logic                             hit,
    output hkc_pkg::key_t                    key_hash,
    output logic                             evicted,
    output hkc_pkg::key_t                    evicted_hash,
    output logic [hkc_pkg::OCC_W-1:0]        occupancy,
    input  logic                             cfg_wr_en,
    input  logic [hkc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hkc_pkg::CFG_W-1:0]        cfg_wdata
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int EW    = (CNT_W > hkc_pkg::CAP_W) ? CNT_W : hkc_pkg::CAP_W;
    localparam int OCC_W = hkc_pkg::OCC_W;
    localparam int KEY_W = hkc_pkg::KEY_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

    // Sequencer states.
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_HASH   = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_DECIDE = 4'd4;
    localparam logic [3:0] S_EVK    = 4'd5;
    localparam logic [3:0] S_EVD    = 4'd6;
    localparam logic [3:0] S_WR1    = 4'd7;
    localparam logic [3:0] S_WR2    = 4'd8;

    logic [3:0]                 state_reg;
    logic [3:0]                 state_next;
    logic                       enable_reg;
    logic [hkc_pkg::CAP_W-1:0]  capacity_reg;
    logic                       mode_reg;
    hkc_pkg::key_t              key_reg;
    hkc_pkg::key_t              key_next;

    logic [IDX_W-1:0]           scan_addr_reg;
    logic [IDX_W-1:0]           scan_addr_next;
    logic                       issue_done_reg;
    logic                       issue_done_next;
    logic                       cmp_vld_reg;
    logic                       cmp_vld_next;
    logic [IDX_W-1:0]           cmp_addr_reg;
    logic [IDX_W-1:0]           cmp_addr_next;
    logic                       cmp_last_reg;
    logic                       cmp_last_next;
    logic                       hit_found_reg;
    logic                       hit_found_next;
    logic                       free_found_reg;
    logic                       free_found_next;
    logic [IDX_W-1:0]           free_slot_reg;
    logic [IDX_W-1:0]           free_slot_next;

    logic [IDX_W-1:0]           old_slot_reg;
    logic [IDX_W-1:0]           old_slot_next;
    logic [IDX_W-1:0]           slot_reg;
    logic [IDX_W-1:0]           slot_next;
    logic                       evict_reg;
    logic                       evict_next;
    logic                       inval_reg;
    logic                       inval_next;
    hkc_pkg::key_t              ev_key_reg;
    hkc_pkg::key_t              ev_key_next;

    logic [IDX_W-1:0]           head_reg;
    logic [IDX_W-1:0]           head_next;
    logic [IDX_W-1:0]           tail_reg;
    logic [IDX_W-1:0]           tail_next;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic [IDX_W-1:0]           clear_addr_reg;
    logic [IDX_W-1:0]           clear_addr_next;

    logic                       done_reg;
    logic                       done_next;
    logic                       hit_reg;
    logic                       hit_next;
    hkc_pkg::key_t              key_hash_reg;
    hkc_pkg::key_t              key_hash_next;
    logic                       evicted_reg;
    logic                       evicted_next;
    hkc_pkg::key_t              evicted_hash_reg;
    hkc_pkg::key_t              evicted_hash_next;
    logic [OCC_W-1:0]           occ_reg;
    logic [OCC_W-1:0]           occ_next;

    // Key store: bit KEY_W is the valid flag, the rest is the stored key.
    logic [KEY_W:0]             key_mem [MAX_ENTRIES];
    logic                       mem_we;
    logic [IDX_W-1:0]           mem_wa;
    logic [KEY_W:0]             mem_wd;
    logic [IDX_W-1:0]           mem_ra;
    logic [KEY_W:0]             mem_rd_reg;

    // Insertion order queue of slot numbers.
    logic [IDX_W-1:0]           ord_mem [MAX_ENTRIES];
    logic                       ord_we;
    logic [IDX_W-1:0]           ord_rd_reg;

    logic                       accept;
    logic                       hash_done;
    hkc_pkg::key_t              hash_key;
    logic [EW-1:0]              cap_ext;
    logic [EW-1:0]              eff_cap;
    logic                       need_evict;
    logic                       fin;
    logic                       fin_hit;
    logic                       cmp_hit;
    logic                       cmp_free;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    hkc_hash u_hash (
        .clk           (clk),
        .rst_n         (rst_n),
        .go            (accept),
        .entity_key    (entity_key),
        .type_code     (type_code),
        .column_number (column_number),
        .done          (hash_done),
        .key_hash      (hash_key)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b1;
            capacity_reg <= hkc_pkg::CAPACITY_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                hkc_pkg::CFG_IDX_ENABLE:   enable_reg   <= cfg_wdata[0];
                hkc_pkg::CFG_IDX_CAPACITY: capacity_reg <= cfg_wdata[hkc_pkg::CAP_W-1:0];
                default:                   ;
            endcase
        end
    end

    // Effective capacity: zero counts as one, large values saturate.
    always_comb
    begin
        cap_ext = EW'(capacity_reg);
        if (cap_ext == '0)
        begin
            eff_cap = EW'(1);
        end
        else if (cap_ext > EW'(MAX_ENTRIES))
        begin
            eff_cap = EW'(MAX_ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign need_evict = (EW'(count_reg) >= eff_cap) && (count_reg != '0);

    // Compare of the entry read in the previous cycle.
    assign cmp_hit  = cmp_vld_reg && mem_rd_reg[KEY_W] && (mem_rd_reg[KEY_W-1:0] == key_reg);
    assign cmp_free = cmp_vld_reg && !mem_rd_reg[KEY_W];

    // Sequencer.
    always_comb
    begin
        state_next        = state_reg;
        key_next          = key_reg;
        scan_addr_next    = scan_addr_reg;
        issue_done_next   = issue_done_reg;
        cmp_vld_next      = 1'b0;
        cmp_addr_next     = cmp_addr_reg;
        cmp_last_next     = cmp_last_reg;
        hit_found_next    = hit_found_reg;
        free_found_next   = free_found_reg;
        free_slot_next    = free_slot_reg;
        old_slot_next     = old_slot_reg;
        slot_next         = slot_reg;
        evict_next        = evict_reg;
        inval_next        = inval_reg;
        ev_key_next       = ev_key_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        count_next        = count_reg;
        clear_addr_next   = clear_addr_reg;
        done_next         = 1'b0;
        hit_next          = hit_reg;
        key_hash_next     = key_hash_reg;
        evicted_next      = evicted_reg;
        evicted_hash_next = evicted_hash_reg;
        occ_next          = occ_reg;
        mem_we            = 1'b0;
        mem_wa            = slot_reg;
        mem_wd            = {1'b1, key_reg};
        mem_ra            = scan_addr_reg;
        ord_we            = 1'b0;
        fin               = 1'b0;
        fin_hit           = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clear_addr_reg;
                mem_wd = '0;
                if (clear_addr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clear_addr_next = clear_addr_reg + IDX_W'(1);
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_HASH;
                end
            end

            S_HASH:
            begin
                if (hash_done)
                begin
                    key_next        = hash_key;
                    scan_addr_next  = '0;
                    issue_done_next = 1'b0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    evict_next      = 1'b0;
                    inval_next      = 1'b0;
                    ev_key_next     = '0;
                    state_next      = enable_reg ? S_SCAN : S_DECIDE;
                end
            end

            S_SCAN:
            begin
                // Issue one read per cycle and compare the one issued before.
                if (!issue_done_reg)
                begin
                    cmp_vld_next  = 1'b1;
                    cmp_addr_next = scan_addr_reg;
                    cmp_last_next = (scan_addr_reg == LAST_IDX);
                    if (scan_addr_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        scan_addr_next = scan_addr_reg + IDX_W'(1);
                    end
                end
                if (cmp_hit)
                begin
                    hit_found_next = 1'b1;
                end
                if (cmp_free && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_slot_next  = cmp_addr_reg;
                end
                if (cmp_vld_reg && cmp_last_reg)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (!enable_reg || (mode_reg == hkc_pkg::MODE_CHECK) || hit_found_reg)
                begin
                    fin     = 1'b1;
                    fin_hit = hit_found_reg;
                end
                else if (need_evict)
                begin
                    evict_next = 1'b1;
                    state_next = S_EVK;
                end
                else if (free_found_reg)
                begin
                    slot_next  = free_slot_reg;
                    state_next = S_WR1;
                end
                else
                begin
                    fin = 1'b1;
                end
            end

            S_EVK:
            begin
                // The head of the queue names the oldest slot; fetch its key.
                mem_ra        = ord_rd_reg;
                old_slot_next = ord_rd_reg;
                state_next    = S_EVD;
            end

            S_EVD:
            begin
                ev_key_next = mem_rd_reg[KEY_W-1:0];
                head_next   = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
                // The first free slot after eviction is the lower of the two.
                if (free_found_reg && (free_slot_reg < old_slot_reg))
                begin
                    slot_next  = free_slot_reg;
                    inval_next = 1'b1;
                end
                else
                begin
                    slot_next  = old_slot_reg;
                    inval_next = 1'b0;
                end
                state_next = S_WR1;
            end

            S_WR1:
            begin
                mem_we    = 1'b1;
                mem_wa    = slot_reg;
                mem_wd    = {1'b1, key_reg};
                ord_we    = 1'b1;
                tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + IDX_W'(1);
                if (!evict_reg)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                if (inval_reg)
                begin
                    state_next = S_WR2;
                end
                else
                begin
                    fin = 1'b1;
                end
            end

            S_WR2:
            begin
                mem_we = 1'b1;
                mem_wa = old_slot_reg;
                mem_wd = {1'b0, key_reg};
                fin    = 1'b1;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Result registers load when the item completes.
        if (fin)
        begin
            state_next        = S_IDLE;
            done_next         = 1'b1;
            hit_next          = fin_hit;
            key_hash_next     = key_reg;
            evicted_next      = evict_reg;
            evicted_hash_next = evict_reg ? ev_key_reg : '0;
            occ_next          = OCC_W'(count_next);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clear_addr_reg <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            done_reg       <= 1'b0;
            issue_done_reg <= 1'b0;
            cmp_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_addr_reg <= clear_addr_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            done_reg       <= done_next;
            issue_done_reg <= issue_done_next;
            cmp_vld_reg    <= cmp_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode;
        end
        key_reg          <= key_next;
        scan_addr_reg    <= scan_addr_next;
        cmp_addr_reg     <= cmp_addr_next;
        cmp_last_reg     <= cmp_last_next;
        hit_found_reg    <= hit_found_next;
        free_found_reg   <= free_found_next;
        free_slot_reg    <= free_slot_next;
        old_slot_reg     <= old_slot_next;
        slot_reg         <= slot_next;
        evict_reg        <= evict_next;
        inval_reg        <= inval_next;
        ev_key_reg       <= ev_key_next;
        hit_reg          <= hit_next;
        key_hash_reg     <= key_hash_next;
        evicted_reg      <= evicted_next;
        evicted_hash_reg <= evicted_hash_next;
        occ_reg          <= occ_next;
    end

    // Key store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[mem_wa] <= mem_wd;
        end
        mem_rd_reg <= key_mem[mem_ra];
    end

    // Order queue: written at the tail, read at the head.
    always_ff @(posedge clk)
    begin
        if (ord_we)
        begin
            ord_mem[tail_reg] <= slot_reg;
        end
        ord_rd_reg <= ord_mem[head_reg];
    end

    assign done         = done_reg;
    assign hit          = hit_reg;
    assign key_hash     = key_hash_reg;
    assign evicted      = evicted_reg;
    assign evicted_hash = evicted_hash_reg;
    assign occupancy    = occ_reg;

    // The entry count never exceeds the number of slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above store depth");

    // An empty cache has an empty order queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) && (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("order queue out of step with entry count");

    // A result that evicts nothing reports a zero evicted hash.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !evicted_reg |-> (evicted_hash_reg == '0))
        else $error("evicted hash set without eviction");

    // Eviction only happens on a miss.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && evicted_reg |-> !hit_reg)
        else $error("eviction reported on a hit");

    // An accepted item makes the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("item accepted but block not busy");

endmodule

// ===== rtl/core/hkc_hash.sv =====
// Iterative FNV-1a style fold of the three request words, one round per cycle.
module hkc_hash (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  hkc_pkg::key_t                 entity_key,
    input  logic [hkc_pkg::TYPE_W-1:0]    type_code,
    input  logic [hkc_pkg::COL_W-1:0]     column_number,
    output logic                          done,
    output hkc_pkg::key_t                 key_hash
);

    localparam logic [1:0] ROUND_ENT  = 2'd0;
    localparam logic [1:0] ROUND_TYPE = 2'd1;
    localparam logic [1:0] ROUND_COL  = 2'd2;

    logic                       run_reg;
    logic                       run_next;
    logic                       done_reg;
    logic                       done_next;
    logic [1:0]                 round_reg;
    logic [1:0]                 round_next;
    hkc_pkg::key_t              h_reg;
    hkc_pkg::key_t              h_next;
    hkc_pkg::key_t              ent_reg;
    logic [hkc_pkg::TYPE_W-1:0] typ_reg;
    logic [hkc_pkg::COL_W-1:0]  col_reg;
    hkc_pkg::key_t              word;
    hkc_pkg::key_t              mixed;
    hkc_pkg::key_t              product;

    // Select the word folded in this round.
    always_comb
    begin
        case (round_reg)
            ROUND_ENT:  word = ent_reg;
            ROUND_TYPE: word = hkc_pkg::KEY_W'(typ_reg);
            ROUND_COL:  word = hkc_pkg::KEY_W'(col_reg);
            default:    word = '0;
        endcase
    end

    // Multiply by the prime as a shift plus a narrow 64 x 9 product.
    assign mixed   = h_reg ^ word;
    assign product = (mixed << hkc_pkg::HASH_PRIME_SHIFT)
                   + (mixed * hkc_pkg::KEY_W'(hkc_pkg::HASH_PRIME_LOW));

    // Round sequencing.
    always_comb
    begin
        run_next   = run_reg;
        round_next = round_reg;
        h_next     = h_reg;
        done_next  = 1'b0;
        if (go)
        begin
            run_next   = 1'b1;
            round_next = ROUND_ENT;
            h_next     = hkc_pkg::HASH_BASIS;
        end
        else if (run_reg)
        begin
            h_next     = product;
            round_next = round_reg + 2'd1;
            if (round_reg == ROUND_COL)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= ROUND_ENT;
        end
        else
        begin
            run_reg   <= run_next;
            done_reg  <= done_next;
            round_reg <= round_next;
        end
    end

    // Operand and accumulator registers carry payload only.
    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
        if (go)
        begin
            ent_reg <= entity_key;
            typ_reg <= type_code;
            col_reg <= column_number;
        end
    end

    assign done     = done_reg;
    assign key_hash = h_reg;

endmodule
